FILE: rtl/core/chmap_pkg.sv
package chmap_pkg;

  // Fixed field widths of the item and result channels.
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned BCNT_W  = 9;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Bucket division steps; remainder one bit wider while a digit is shifted in.
  localparam int unsigned DIGITS_PER_CYCLE = 4;
  localparam int unsigned DIV_CYCLES       = KEY_W / DIGITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W        = $clog2(DIV_CYCLES);

  // Register indexes of the configuration port.
  localparam logic [PADDR_W-1:0] REG_BUCKET_COUNT = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DIV      = 9'b000000100,
    S_HEAD     = 9'b000001000,
    S_DISPATCH = 9'b000010000,
    S_FETCH    = 9'b000100000,
    S_CHECK    = 9'b001000000,
    S_FREE     = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

endpackage

FILE: rtl/core/chained_hash_map_engine_core.sv
// Separate-chaining hash map over a fixed pool of NODES nodes and BUCKETS chain heads.
// Input channel (in_valid/in_ready): one item carries a command (lookup, insert,
// remove), a key and, for inserts, a value. Result channel (out_valid/out_ready):
// exactly one result per item with found, read_value, status and the live count.
// The bucket is the key modulo the effective bucket_count, written over the APB port.
// Items are handled one at a time. After its accepting cycle an item passes through the
// remainder unit (four key bits a cycle) and the bucket head read (S_HEAD, S_DISPATCH),
// then: insert and unused command go on to S_RESP; lookup and remove visit the chain
// node by node (one node memory read each, S_FETCH then S_CHECK) until the key is found
// or the chain ends; a remove that hits adds the free-list write in S_FREE.
// The next item is taken only after the result is loaded into the output register.
// The result sits in an output register; a new item is accepted while it waits,
// but the block holds the next result until the receiver has taken the last one.
// After reset the block clears the bucket heads, one a cycle, before it accepts
// its first item; configuration writes are taken throughout.
module chained_hash_map_engine_core #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned NODES   = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [chmap_pkg::CMD_W-1:0]       in_command,
  input  logic [chmap_pkg::KEY_W-1:0]       in_key,
  input  logic [chmap_pkg::VAL_W-1:0]       in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [chmap_pkg::VAL_W-1:0]       out_read_value,
  output logic                              out_status,
  output logic [chmap_pkg::CNT_W-1:0]       out_live_count,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [chmap_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [chmap_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [chmap_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                              cfg_pready
);
  import chmap_pkg::*;

  localparam int unsigned NW  = $clog2(NODES + 1);
  localparam int unsigned IW  = $clog2(NODES);
  localparam int unsigned BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [NW-1:0] NIL = NW'(NODES);
  localparam logic [BIW-1:0] LAST_BUCKET = BIW'(BUCKETS - 1);

  typedef struct packed {
    logic [NW-1:0]    nxt;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } node_t;

  // Storage: chain heads and the node pool.
  logic [NW-1:0] head_mem [BUCKETS];
  node_t         node_mem [NODES];

  state_t state_r, state_nxt;
  logic [BCNT_W-1:0] bcount_r;
  logic [BIW-1:0] clr_r, clr_nxt;
  cmd_t cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [KEY_W-1:0] ksh_r, ksh_nxt;
  logic [BCNT_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [BIW-1:0] bucket_r, bucket_nxt;
  logic [NW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  node_t prev_word_r, prev_word_nxt, cur_word_r, cur_word_nxt;
  logic [NW-1:0] free_head_r, free_head_nxt;
  logic [NW-1:0] fresh_r, fresh_nxt;
  logic [NW-1:0] total_r, total_nxt;
  logic found_r, found_nxt, status_r, status_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  logic out_valid_r;
  logic out_found_r, out_status_r;
  logic [VAL_W-1:0] out_rv_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [NW-1:0] hd_q;
  node_t nd_q;
  logic hw_en, nw_en;
  logic [BIW-1:0] hw_addr;
  logic [NW-1:0] hw_data;
  logic [IW-1:0] nw_addr, nr_addr;
  node_t nw_data;
  logic [BCNT_W-1:0] eff;
  logic [BCNT_W:0] dtmp;
  logic cfg_wr, in_acc, out_load;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_BUCKET_COUNT) ?
                      PDATA_W'(bcount_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= BCNT_W'(BUCKETS);
    end else if (cfg_wr && cfg_paddr[2] == REG_BUCKET_COUNT[2]) begin
      bcount_r <= cfg_pwdata[BCNT_W-1:0];
    end
  end

  // Effective bucket count: zero acts as one, anything above BUCKETS as BUCKETS.
  always_comb begin
    if (bcount_r == '0) begin
      eff = BCNT_W'(1);
    end else if (32'(bcount_r) > BUCKETS) begin
      eff = BCNT_W'(BUCKETS);
    end else begin
      eff = bcount_r;
    end
  end

  // Handshakes.
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign out_found      = out_found_r;
  assign out_read_value = out_rv_r;
  assign out_status     = out_status_r;
  assign out_live_count = out_cnt_r;

  // Node memory read address: the free-list head while the bucket head is read,
  // otherwise the chain node being visited.
  assign nr_addr = (state_r == S_HEAD) ? free_head_r[IW-1:0] : cur_r[IW-1:0];

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (hw_en) begin
      head_mem[hw_addr] <= hw_data;
    end
    hd_q <= head_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      node_mem[nw_addr] <= nw_data;
    end
    nd_q <= node_mem[nr_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ksh_nxt       = ksh_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    bucket_nxt    = bucket_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    prev_word_nxt = prev_word_r;
    cur_word_nxt  = cur_word_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    hw_en   = 1'b0;
    hw_addr = bucket_r;
    hw_data = NIL;
    nw_en   = 1'b0;
    nw_addr = cur_r[IW-1:0];
    nw_data = cur_word_r;
    dtmp    = '0;
    case (state_r)
      S_CLEAR: begin
        hw_en   = 1'b1;
        hw_addr = clr_r;
        hw_data = NIL;
        clr_nxt = clr_r + BIW'(1);
        if (clr_r == LAST_BUCKET) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ksh_nxt    = in_key;
          rem_nxt    = '0;
          dcnt_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = 1'b0;
          rv_nxt     = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring remainder, four key bits a cycle, most significant first.
        for (int i = 0; i < DIGITS_PER_CYCLE; i++) begin
          dtmp = {rem_nxt, ksh_nxt[KEY_W-1]};
          if (dtmp >= {1'b0, eff}) begin
            dtmp = dtmp - {1'b0, eff};
          end
          rem_nxt = dtmp[BCNT_W-1:0];
          ksh_nxt = {ksh_nxt[KEY_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          bucket_nxt = BIW'(rem_nxt);
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd_r)
          CMD_INSERT: begin
            state_nxt = S_RESP;
            if (free_head_r < NIL || fresh_r < NIL) begin
              if (free_head_r < NIL) begin
                cur_nxt       = free_head_r;
                free_head_nxt = (nd_q.nxt > NIL) ? NIL : nd_q.nxt;
              end else begin
                cur_nxt   = fresh_r;
                fresh_nxt = fresh_r + NW'(1);
              end
              nw_en       = 1'b1;
              nw_addr     = cur_nxt[IW-1:0];
              nw_data.nxt = hd_q;
              nw_data.key = key_r;
              nw_data.val = val_r;
              hw_en       = 1'b1;
              hw_addr     = bucket_r;
              hw_data     = cur_nxt;
              total_nxt   = total_r + NW'(1);
            end else begin
              status_nxt = 1'b1;
            end
          end
          CMD_LOOKUP, CMD_REMOVE: begin
            cur_nxt   = hd_q;
            prev_nxt  = NIL;
            state_nxt = S_FETCH;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FETCH: begin
        state_nxt = (cur_r < NIL) ? S_CHECK : S_RESP;
      end
      S_CHECK: begin
        cur_word_nxt = nd_q;
        if (nd_q.key == key_r) begin
          found_nxt = 1'b1;
          if (cmd_r == CMD_LOOKUP) begin
            rv_nxt    = nd_q.val;
            state_nxt = S_RESP;
          end else begin
            // Unlink the match from its predecessor or from the chain head.
            if (prev_r < NIL) begin
              nw_en       = 1'b1;
              nw_addr     = prev_r[IW-1:0];
              nw_data     = prev_word_r;
              nw_data.nxt = nd_q.nxt;
            end else begin
              hw_en   = 1'b1;
              hw_addr = bucket_r;
              hw_data = nd_q.nxt;
            end
            state_nxt = S_FREE;
          end
        end else begin
          prev_nxt      = cur_r;
          prev_word_nxt = nd_q;
          cur_nxt       = nd_q.nxt;
          state_nxt     = S_FETCH;
        end
      end
      S_FREE: begin
        // Push the removed node onto the free list.
        nw_en         = 1'b1;
        nw_addr       = cur_r[IW-1:0];
        nw_data       = cur_word_r;
        nw_data.nxt   = free_head_r;
        free_head_nxt = cur_r;
        if (total_r != '0) begin
          total_nxt = total_r - NW'(1);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= NIL;
      fresh_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      total_r     <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_t'(in_command);
      key_r <= in_key;
      val_r <= in_value;
    end
    ksh_r       <= ksh_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    bucket_r    <= bucket_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    prev_word_r <= prev_word_nxt;
    cur_word_r  <= cur_word_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    rv_r        <= rv_nxt;
    if (out_load) begin
      out_found_r  <= found_r;
      out_status_r <= status_r;
      out_rv_r     <= rv_r;
      out_cnt_r    <= CNT_W'(total_r);
    end
  end

endmodule
